FILE: hdl/hill_2x2_key_recovery_mod26_core_macros.svh
// Assertion macros shared by the key recovery core.
`ifndef HILL_2X2_KEY_RECOVERY_MOD26_CORE_MACROS_SVH
`define HILL_2X2_KEY_RECOVERY_MOD26_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define HK_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hill key core: implication failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define HK_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hill key core: next-cycle implication failed");
`else
`define HK_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define HK_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/hk_pkg.sv
package hk_pkg;

  // Alphabet size; every matrix entry lives in 0..25.
  localparam int unsigned Letters = 26;

  // One letter value and a 2x2 matrix of them.
  typedef logic [4:0] res_t;

  typedef struct packed {
    res_t r0c0;
    res_t r0c1;
    res_t r1c0;
    res_t r1c1;
  } mat_t;

  // Control that travels with an item from stage to stage.
  typedef struct packed {
    logic vld;
    logic inv_ok;
  } ctrl_t;

  // Reduce an 11-bit value mod 26 with a reciprocal multiply.
  // 2521 / 2^16 sits just above 1/26, so the quotient is exact for
  // every 11-bit input; the final compare is a safety net.
  function automatic res_t mod26(input logic [10:0] v);
    logic [22:0] prod;
    logic [6:0]  quo;
    logic [11:0] rem;
    prod = 23'(v) * 23'd2521;
    quo  = prod[22:16];
    rem  = {1'b0, v} - (12'(quo) * 12'(Letters));
    if (rem >= 12'(Letters)) begin
      rem = rem - 12'(Letters);
    end
    return rem[4:0];
  endfunction

  // Fold a raw 5-bit letter value into 0..25.
  function automatic res_t fold(input logic [4:0] v);
    return (v >= 5'(Letters)) ? (v - 5'(Letters)) : v;
  endfunction

  // Negate a residue mod 26.
  function automatic res_t neg26(input res_t v);
    return (v == '0) ? '0 : (5'(Letters) - v);
  endfunction

  // Inverse of a residue mod 26; zero marks a residue with no inverse.
  function automatic res_t inv26(input res_t v);
    res_t r;
    case (v)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/hk_matmul.sv
// Key product stage pair: K = inv(P) * C mod 26, zeroed when P is singular.
module hk_matmul (
  input  logic          clk,
  input  logic          rst,
  input  hk_pkg::ctrl_t ctl_in,
  input  hk_pkg::mat_t  pinv,
  input  hk_pkg::mat_t  cmat,
  output logic          vld_out,
  output logic          ok_out,
  output hk_pkg::mat_t  key
);

  // Stage one: dot products of the inverse rows with the cipher columns.
  logic [10:0]   sum00, sum01, sum10, sum11;
  logic          vld_s;
  logic          ok_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s <= 1'b0;
    end else begin
      vld_s <= ctl_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    ok_s  <= ctl_in.inv_ok;
    sum00 <= 11'(10'(pinv.r0c0) * 10'(cmat.r0c0)) + 11'(10'(pinv.r0c1) * 10'(cmat.r1c0));
    sum01 <= 11'(10'(pinv.r0c0) * 10'(cmat.r0c1)) + 11'(10'(pinv.r0c1) * 10'(cmat.r1c1));
    sum10 <= 11'(10'(pinv.r1c0) * 10'(cmat.r0c0)) + 11'(10'(pinv.r1c1) * 10'(cmat.r1c0));
    sum11 <= 11'(10'(pinv.r1c0) * 10'(cmat.r0c1)) + 11'(10'(pinv.r1c1) * 10'(cmat.r1c1));
  end

  // Stage two: reduce and clear the key when no inverse exists.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_s;
    end
  end

  always_ff @(posedge clk) begin
    ok_out <= ok_s;
    if (ok_s) begin
      key.r0c0 <= hk_pkg::mod26(sum00);
      key.r0c1 <= hk_pkg::mod26(sum01);
      key.r1c0 <= hk_pkg::mod26(sum10);
      key.r1c1 <= hk_pkg::mod26(sum11);
    end else begin
      key <= '0;
    end
  end

endmodule

FILE: hdl/hill_2x2_key_recovery_mod26_core.sv
// Hill cipher 2x2 key recovery, mod 26.
// Input: drive the plaintext matrix plain_* and ciphertext matrix cipher_*
// and raise start; the item is taken at a rising edge with start high and
// busy low. busy is high only during reset, so a new item can enter in
// every cycle.
// Output: for each item taken, done is high for one cycle with key_* and
// key_valid for that item. key_valid is low and all key fields are zero
// when det(P) has no inverse mod 26.
// Throughput is one item per cycle. Each item passes through seven register
// stages: fold and products, determinant reduction, inverse lookup,
// adjugate scaling, its reduction, the key dot products and the final
// reduction.
// Reset (rst, synchronous) clears the stage valid bits, so items in flight
// are dropped and no done pulse follows them.
// The receiver cannot stall: results are shown once and not held.
`include "hill_2x2_key_recovery_mod26_core_macros.svh"

module hill_2x2_key_recovery_mod26_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [4:0] plain_r0c0,
  input  logic [4:0] plain_r0c1,
  input  logic [4:0] plain_r1c0,
  input  logic [4:0] plain_r1c1,
  input  logic [4:0] cipher_r0c0,
  input  logic [4:0] cipher_r0c1,
  input  logic [4:0] cipher_r1c0,
  input  logic [4:0] cipher_r1c1,
  output logic       done,
  output logic [4:0] key_r0c0,
  output logic [4:0] key_r0c1,
  output logic [4:0] key_r1c0,
  output logic [4:0] key_r1c1,
  output logic       key_valid
);

  // Items are refused only while reset holds the pipeline empty.
  assign busy = rst;

  logic         vld1, vld2, vld3, vld4, vld5;
  hk_pkg::mat_t p1, c1, c2, c3, c4, c5;
  logic [9:0]   prod_main, prod_anti;
  hk_pkg::res_t det2;
  hk_pkg::mat_t adj3, pinv5;
  hk_pkg::res_t dinv3;
  logic         ok3, ok4, ok5;
  logic [9:0]   sc00, sc01, sc10, sc11;
  hk_pkg::ctrl_t ctl5;
  hk_pkg::mat_t key_m;
  logic         key_ok;

  // Valid bits through the first five stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
      vld5 <= 1'b0;
    end else begin
      vld1 <= start & ~busy;
      vld2 <= vld1;
      vld3 <= vld2;
      vld4 <= vld3;
      vld5 <= vld4;
    end
  end

  // Stage 1: fold letters into 0..25 and form the determinant products.
  always_ff @(posedge clk) begin
    p1.r0c0   <= hk_pkg::fold(plain_r0c0);
    p1.r0c1   <= hk_pkg::fold(plain_r0c1);
    p1.r1c0   <= hk_pkg::fold(plain_r1c0);
    p1.r1c1   <= hk_pkg::fold(plain_r1c1);
    c1.r0c0   <= hk_pkg::fold(cipher_r0c0);
    c1.r0c1   <= hk_pkg::fold(cipher_r0c1);
    c1.r1c0   <= hk_pkg::fold(cipher_r1c0);
    c1.r1c1   <= hk_pkg::fold(cipher_r1c1);
    prod_main <= 10'(hk_pkg::fold(plain_r0c0)) * 10'(hk_pkg::fold(plain_r1c1));
    prod_anti <= 10'(hk_pkg::fold(plain_r0c1)) * 10'(hk_pkg::fold(plain_r1c0));
  end

  // Stage 2: determinant mod 26, biased by 26*26 to stay positive.
  hk_pkg::mat_t p2;
  always_ff @(posedge clk) begin
    det2 <= hk_pkg::mod26(11'(prod_main) + 11'(hk_pkg::Letters * hk_pkg::Letters)
                          - 11'(prod_anti));
    p2   <= p1;
    c2   <= c1;
  end

  // Stage 3: inverse lookup and the adjugate with negated off-diagonals.
  always_ff @(posedge clk) begin
    dinv3     <= hk_pkg::inv26(det2);
    ok3       <= (hk_pkg::inv26(det2) != '0);
    adj3.r0c0 <= p2.r1c1;
    adj3.r0c1 <= hk_pkg::neg26(p2.r0c1);
    adj3.r1c0 <= hk_pkg::neg26(p2.r1c0);
    adj3.r1c1 <= p2.r0c0;
    c3        <= c2;
  end

  // Stage 4: scale the adjugate by the determinant inverse.
  always_ff @(posedge clk) begin
    sc00 <= 10'(adj3.r0c0) * 10'(dinv3);
    sc01 <= 10'(adj3.r0c1) * 10'(dinv3);
    sc10 <= 10'(adj3.r1c0) * 10'(dinv3);
    sc11 <= 10'(adj3.r1c1) * 10'(dinv3);
    ok4  <= ok3;
    c4   <= c3;
  end

  // Stage 5: reduce the scaled adjugate to the inverse of P.
  always_ff @(posedge clk) begin
    pinv5.r0c0 <= hk_pkg::mod26(11'(sc00));
    pinv5.r0c1 <= hk_pkg::mod26(11'(sc01));
    pinv5.r1c0 <= hk_pkg::mod26(11'(sc10));
    pinv5.r1c1 <= hk_pkg::mod26(11'(sc11));
    ok5        <= ok4;
    c5         <= c4;
  end

  assign ctl5.vld    = vld5;
  assign ctl5.inv_ok = ok5;

  // Stages 6 and 7: key product and final reduction.
  hk_matmul u_matmul (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl5),
    .pinv    (pinv5),
    .cmat    (c5),
    .vld_out (done),
    .ok_out  (key_ok),
    .key     (key_m)
  );

  assign key_r0c0  = key_m.r0c0;
  assign key_r0c1  = key_m.r0c1;
  assign key_r1c0  = key_m.r1c0;
  assign key_r1c1  = key_m.r1c1;
  assign key_valid = key_ok;

  // A delivered key is always a letter value.
  `HK_ASSERT_IMP(a_key_range, clk, rst, done,
                 key_r0c0 < 5'd26 && key_r0c1 < 5'd26 && key_r1c0 < 5'd26 && key_r1c1 < 5'd26)
  // A singular determinant gives an all-zero key.
  `HK_ASSERT_IMP(a_key_zero, clk, rst, done && !key_valid,
                 key_r0c0 == '0 && key_r0c1 == '0 && key_r1c0 == '0 && key_r1c1 == '0)
  // An invertible determinant is odd and has an odd inverse.
  `HK_ASSERT_IMP(a_inv_odd, clk, rst, vld3 && ok3, dinv3[0] == 1'b1)
  // A stage-five item reaches done through the key product and final reduction stages.
  `HK_ASSERT_NXT(a_flow, clk, rst, vld5, ##1 done)

endmodule
